@@ rtl/core/assert_macros.svh @@
// assertion macros used by the fnr_checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FNR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FNR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/fnr_pkg.sv @@
// shared types and constants for the fraction normalize and reduce block
`default_nettype none

package fnr_pkg;

   localparam int FNR_WIDTH = 32;
   localparam int FNR_MAG_W = FNR_WIDTH - 1;
   localparam int FNR_CNT_W = $clog2(FNR_MAG_W + 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NULL_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [FNR_WIDTH-1:0] numer_in;
      logic signed [FNR_WIDTH-1:0] denom_in;
   } fnr_req_type;

   typedef struct packed {
      logic signed [FNR_WIDTH-1:0] numer_out;
      logic [FNR_MAG_W-1:0]        denom_out;
      logic [1:0]                  status;
   } fnr_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [FNR_MAG_W-1:0] dividend;
      logic [FNR_MAG_W-1:0] divisor;
   } fnr_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FNR_MAG_W-1:0] quot;
      logic [FNR_MAG_W-1:0] rem;
   } fnr_div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_GCD_WAIT,
      ST_DIVN,
      ST_DIVN_WAIT,
      ST_DIVD,
      ST_DIVD_WAIT,
      ST_FINISH
   } fnr_state_type;

endpackage

`default_nettype wire

@@ rtl/core/fnr_divider.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module fnr_divider (
   input  wire                       clock,
   input  wire                       reset,
   input  fnr_pkg::fnr_div_req_type  div_req,
   output fnr_pkg::fnr_div_rsp_type  div_rsp
);
   import fnr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FNR_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FNR_MAG_W-1:0] rem_ff, rem_in;
   logic [FNR_MAG_W-1:0] quot_ff, quot_in;
   logic [FNR_MAG_W-1:0] dvsr_ff, dvsr_in;
   logic [FNR_MAG_W:0]   shifted;
   logic [FNR_MAG_W:0]   diff;

   assign shifted = {rem_ff, quot_ff[FNR_MAG_W-1]};
   assign diff    = shifted - {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = FNR_CNT_W'(FNR_MAG_W);
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvsr_ff}) begin
            rem_in  = diff[FNR_MAG_W-1:0];
            quot_in = {quot_ff[FNR_MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[FNR_MAG_W-1:0];
            quot_in = {quot_ff[FNR_MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - FNR_CNT_W'(1);
         if (cnt_ff == FNR_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

@@ rtl/core/fraction_normalize_reduce.sv @@
// top level: normalizes a signed fraction and reduces it to lowest terms
// One fraction at a time: req_ready is high only while the sequencer is idle. Zero
// denominator, most negative input and zero numerator skip the divider and go straight
// to the finish state. Otherwise a single 31-step restoring divider does all the work:
// one division per Euclid remainder step, then one each for numerator and denominator
// (k remainder steps, k at most about 45). A finished beat sits in the output register
// while the next fraction is accepted.
`default_nettype none

module fraction_normalize_reduce (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  fnr_pkg::fnr_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output fnr_pkg::fnr_rsp_type rsp_data
);
   import fnr_pkg::*;

   localparam logic [FNR_WIDTH-1:0] MOST_NEG = {1'b1, {FNR_MAG_W{1'b0}}};

   fnr_state_type state_ff, state_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   fnr_rsp_type          rsp_ff, rsp_in;
   logic [FNR_MAG_W-1:0] an_ff, an_in;
   logic [FNR_MAG_W-1:0] ad_ff, ad_in;
   logic [FNR_MAG_W-1:0] big_ff, big_in;
   logic [FNR_MAG_W-1:0] small_ff, small_in;
   logic                 neg_ff, neg_in;
   logic [1:0]           status_ff, status_in;

   fnr_div_req_type      div_req;
   fnr_div_rsp_type      div_rsp;

   logic                 req_beat;
   logic                 out_free;
   logic                 special;
   logic [FNR_WIDTH-1:0] n_raw, d_raw, n_neg, d_neg;
   logic [FNR_MAG_W-1:0] n_mag, d_mag;
   logic [FNR_WIDTH-1:0] mag_ext;

   fnr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_beat = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign n_raw = req_data.numer_in;
   assign d_raw = req_data.denom_in;
   assign n_neg = (~n_raw) + FNR_WIDTH'(1);
   assign d_neg = (~d_raw) + FNR_WIDTH'(1);
   assign n_mag = n_raw[FNR_WIDTH-1] ? n_neg[FNR_MAG_W-1:0] : n_raw[FNR_MAG_W-1:0];
   assign d_mag = d_raw[FNR_WIDTH-1] ? d_neg[FNR_MAG_W-1:0] : d_raw[FNR_MAG_W-1:0];
   assign special = (d_raw == '0) || (n_raw == MOST_NEG) || (d_raw == MOST_NEG)
                    || (n_raw == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = special ? ST_FINISH : ST_GCD;
         end
         ST_GCD:       state_in = ST_GCD_WAIT;
         ST_GCD_WAIT: begin
            if (div_rsp.done) state_in = (div_rsp.rem == '0) ? ST_DIVN : ST_GCD;
         end
         ST_DIVN:      state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: begin
            if (div_rsp.done) state_in = ST_DIVD;
         end
         ST_DIVD:      state_in = ST_DIVD_WAIT;
         ST_DIVD_WAIT: begin
            if (div_rsp.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = big_ff;
      div_req.divisor  = small_ff;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_GCD:  div_req.start = 1'b1;
         ST_DIVN: begin
            div_req.start    = 1'b1;
            div_req.dividend = an_ff;
            div_req.divisor  = big_ff;
         end
         ST_DIVD: begin
            div_req.start    = 1'b1;
            div_req.dividend = ad_ff;
            div_req.divisor  = big_ff;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      an_in        = an_ff;
      ad_in        = ad_ff;
      big_in       = big_ff;
      small_in     = small_ff;
      neg_in       = neg_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mag_ext      = {1'b0, an_ff};
      if (req_beat) begin
         neg_in   = n_raw[FNR_WIDTH-1] ^ d_raw[FNR_WIDTH-1];
         an_in    = n_mag;
         ad_in    = d_mag;
         big_in   = (n_mag >= d_mag) ? n_mag : d_mag;
         small_in = (n_mag >= d_mag) ? d_mag : n_mag;
         if (d_raw == '0) begin
            status_in = STATUS_NULL_DEN;
            an_in     = '0;
            ad_in     = '0;
         end else if ((n_raw == MOST_NEG) || (d_raw == MOST_NEG)) begin
            status_in = STATUS_OVERFLOW;
            an_in     = '0;
            ad_in     = '0;
         end else begin
            status_in = STATUS_OK;
         end
      end
      if (div_rsp.done) begin
         case (state_ff)
            ST_GCD_WAIT: begin
               big_in   = small_ff;
               small_in = div_rsp.rem;
            end
            ST_DIVN_WAIT: an_in = div_rsp.quot;
            ST_DIVD_WAIT: ad_in = div_rsp.quot;
            default: ;
         endcase
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.numer_out = neg_ff ? ((~mag_ext) + FNR_WIDTH'(1)) : mag_ext;
         rsp_in.denom_out = ad_ff;
         rsp_in.status    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      an_ff     <= an_in;
      ad_ff     <= ad_in;
      big_ff    <= big_in;
      small_ff  <= small_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/fnr_checker.sv @@
// port-level checks for the fraction normalize and reduce block
`default_nettype none
`include "assert_macros.svh"

module fnr_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input fnr_pkg::fnr_rsp_type rsp_data
);
   import fnr_pkg::*;

   logic rsp_stall;
   logic rsp_fail;
   logic rsp_ok;
   logic fields_zero;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_fail    = rsp_valid && (rsp_data.status != STATUS_OK);
   assign rsp_ok      = rsp_valid && (rsp_data.status == STATUS_OK);
   assign fields_zero = (rsp_data.numer_out == '0) && (rsp_data.denom_out == '0);

   `FNR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `FNR_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_data.status <= STATUS_OVERFLOW)
   `FNR_ASSERT_SAME(a_fail_zero, clock, reset, rsp_fail, fields_zero)
   `FNR_ASSERT_SAME(a_ok_denom, clock, reset, rsp_ok, rsp_data.denom_out != '0)

endmodule

bind fraction_normalize_reduce fnr_checker u_fnr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ tb/tb_fraction_normalize_reduce.sv @@
// testbench for fraction_normalize_reduce: directed and random fractions checked against a predictor
module tb_fraction_normalize_reduce;
   timeunit 1ns;
   timeprecision 1ps;

   import fnr_pkg::*;

   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int DRAIN_CYCLES = 2000;
   localparam int HOLD_CYCLES  = 3000;

   localparam logic [FNR_WIDTH-1:0] MOST_NEG = {1'b1, {(FNR_WIDTH-1){1'b0}}};
   localparam logic [FNR_WIDTH-1:0] MOST_POS = {1'b0, {(FNR_WIDTH-1){1'b1}}};
   localparam logic [FNR_WIDTH-1:0] FIB_46   = 32'd1836311903;
   localparam logic [FNR_WIDTH-1:0] FIB_45   = 32'd1134903170;

   typedef enum logic [1:0] {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_style_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   fnr_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   fnr_rsp_type rsp_data;

   fnr_rsp_type     expected_fractions[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   bit              no_gaps = 1'b0;
   int              hold_request = 0;
   int              hold_left = 0;
   ready_style_type ready_style = READY_ALWAYS;
   logic [15:0]     stall_pattern = 16'hffff;

   fraction_normalize_reduce uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic fnr_rsp_type predict_fraction(input fnr_req_type item);
      fnr_rsp_type          result;
      logic [FNR_WIDTH-1:0] numer;
      logic [FNR_WIDTH-1:0] denom;
      logic [FNR_WIDTH-1:0] mag_numer;
      logic [FNR_WIDTH-1:0] mag_denom;
      logic [FNR_WIDTH-1:0] big;
      logic [FNR_WIDTH-1:0] little;
      logic [FNR_WIDTH-1:0] remainder;
      result = '0;
      numer = item.numer_in;
      denom = item.denom_in;
      if (denom == '0) begin
         result.status = STATUS_NULL_DEN;
      end else if (numer == MOST_NEG || denom == MOST_NEG) begin
         result.status = STATUS_OVERFLOW;
      end else begin
         mag_numer = numer[FNR_WIDTH-1] ? -numer : numer;
         mag_denom = denom[FNR_WIDTH-1] ? -denom : denom;
         if (mag_numer != '0) begin
            big    = (mag_numer >= mag_denom) ? mag_numer : mag_denom;
            little = (mag_numer >= mag_denom) ? mag_denom : mag_numer;
            while (little != '0) begin
               remainder = big % little;
               big       = little;
               little    = remainder;
            end
            mag_numer = mag_numer / big;
            mag_denom = mag_denom / big;
         end
         result.numer_out = (numer[FNR_WIDTH-1] != denom[FNR_WIDTH-1]) ? -mag_numer : mag_numer;
         result.denom_out = mag_denom[FNR_MAG_W-1:0];
         result.status    = STATUS_OK;
      end
      return result;
   endfunction

   task automatic check_field(input string field, input logic [FNR_WIDTH-1:0] want,
                              input logic [FNR_WIDTH-1:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("mismatch on %s: expected %h, actual %h", field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic send_fraction(input logic [FNR_WIDTH-1:0] numer,
                                input logic [FNR_WIDTH-1:0] denom);
      fnr_req_type item;
      int          gap;
      item.numer_in = numer;
      item.denom_in = denom;
      if (burst_left == 0 && !no_gaps) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_fractions.push_back(predict_fraction(item));
   endtask

   // receiver
   initial begin
      int phase;
      phase = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 0;
         end
         phase = (phase + 1) % 16;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_style)
               READY_PATTERN: rsp_ready <= stall_pattern[phase];
               READY_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
               default:       rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      fnr_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_fractions.size() == 0) begin
            if (mismatch_count < 10)
               $display("result beat with nothing expected: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_fractions.pop_front();
            check_field("numer_out", want.numer_out, rsp_data.numer_out);
            check_field("denom_out", want.denom_out, rsp_data.denom_out);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_fraction_normalize_reduce: errors");
      $finish;
   end

   task automatic pick_stall_pattern();
      stall_pattern = 16'($urandom) | 16'h0001;
   endtask

   task automatic test_directed();
      ready_style = READY_RANDOM;
      send_fraction(32'd6, 32'd4);
      send_fraction(32'd0, 32'd0);
      send_fraction(MOST_NEG, 32'd0);
      send_fraction(MOST_NEG, 32'd5);
      send_fraction(32'd5, MOST_NEG);
      send_fraction(MOST_NEG, MOST_NEG);
      send_fraction(32'd0, -32'sd7);
      send_fraction(32'd0, 32'd7);
      send_fraction(32'd7, -32'sd14);
      send_fraction(-32'sd9, -32'sd12);
      send_fraction(MOST_POS, MOST_POS);
      send_fraction(-MOST_POS, MOST_POS);
      send_fraction(MOST_POS, 32'd1);
      send_fraction(32'd1, MOST_POS);
      send_fraction(-32'sd1, -MOST_POS);
      send_fraction(FIB_46, FIB_45);
      send_fraction(-FIB_45, FIB_46);
      send_fraction(32'd12, 32'd0);
      send_fraction(-32'sd1, 32'd0);
      send_fraction(32'd1, 32'd1);
      send_fraction(32'd100, -32'sd1);
      send_fraction(MOST_POS, -32'sd2);
      send_fraction(32'h4000_0000, 32'h2000_0000);
   endtask

   task automatic send_small_fraction();
      int numer;
      int denom;
      numer = int'($urandom_range(0, 510)) - 255;
      denom = int'($urandom_range(0, 510)) - 255;
      send_fraction(numer, denom);
   endtask

   task automatic send_common_factor_fraction();
      int factor;
      int numer;
      int denom;
      factor = $urandom_range(1, 5000);
      numer  = $urandom_range(0, 400) * factor;
      denom  = $urandom_range(1, 400) * factor;
      if ($urandom_range(0, 1)) numer = -numer;
      if ($urandom_range(0, 1)) denom = -denom;
      send_fraction(numer, denom);
   endtask

   task automatic send_full_fraction();
      logic [FNR_WIDTH-1:0] numer;
      logic [FNR_WIDTH-1:0] denom;
      numer = $urandom;
      denom = $urandom;
      case ($urandom_range(0, 15))
         0:       denom = '0;
         1:       numer = MOST_NEG;
         2:       denom = MOST_NEG;
         3:       numer = '0;
         default: ;
      endcase
      send_fraction(numer, denom);
   endtask

   task automatic test_small_random(input int count);
      pick_stall_pattern();
      ready_style = READY_PATTERN;
      repeat (count) send_small_fraction();
   endtask

   task automatic test_common_factor(input int count);
      ready_style = READY_RANDOM;
      repeat (count) send_common_factor_fraction();
   endtask

   task automatic test_full_random(input int count);
      int n;
      ready_style = READY_ALWAYS;
      for (n = 0; n < count; n++) begin
         if (n == count / 2) begin
            pick_stall_pattern();
            ready_style = READY_PATTERN;
         end
         send_full_fraction();
      end
   endtask

   task automatic test_backpressure(input int count);
      ready_style  = READY_ALWAYS;
      no_gaps      = 1'b1;
      hold_request = 1;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0:       send_fraction($urandom, 32'd0);
            1:       send_fraction(MOST_NEG, $urandom);
            2:       send_fraction(32'd0, $urandom | 32'd1);
            default: send_small_fraction();
         endcase
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_mixed(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            pick_stall_pattern();
            ready_style = ready_style_type'($urandom_range(0, 2));
         end
         case ($urandom_range(0, 2))
            0:       send_small_fraction();
            1:       send_common_factor_fraction();
            default: send_full_fraction();
         endcase
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_small_random(300);
      test_common_factor(300);
      test_full_random(400);
      test_backpressure(60);
      test_mixed(100);

      req_valid   <= 1'b0;
      ready_style = READY_ALWAYS;
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_fraction_normalize_reduce: clean");
      end else begin
         $display("tb_fraction_normalize_reduce: errors");
      end
      $finish;
   end

endmodule
